@@ hdl/tfcc_pkg.sv @@
`timescale 1ns / 1ps

package tfcc_pkg;

    // Screen width is a power of two, so the step division is a shift.
    localparam int SCREEN_WIDTH_LOG2 = 10;
    localparam int SCREEN_WIDTH      = 1 << SCREEN_WIDTH_LOG2;

    // Command codes of an input item.
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    // Register indexes.
    localparam logic [2:0] REG_POS_X      = 3'd0;
    localparam logic [2:0] REG_POS_Y      = 3'd1;
    localparam logic [2:0] REG_DIR_X      = 3'd2;
    localparam logic [2:0] REG_DIR_Y      = 3'd3;
    localparam logic [2:0] REG_PLANE_X    = 3'd4;
    localparam logic [2:0] REG_PLANE_Y    = 3'd5;
    localparam logic [2:0] REG_VIEW_PITCH = 3'd6;
    localparam logic [2:0] REG_EYE_HEIGHT = 3'd7;

    typedef struct packed {
        logic        command;
        logic        surface;
        logic [11:0] texel_index;
        logic [31:0] texel_color;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
    } in_item_t;

    typedef struct packed {
        logic        valid_res;
        logic [19:0] dest_index;
        logic [31:0] color;
    } out_item_t;

    // Camera registers as seen by the row set-up.
    typedef struct packed {
        logic        [25:0] pos_x;
        logic        [25:0] pos_y;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] plane_x;
        logic signed [17:0] plane_y;
        logic signed [10:0] view_pitch;
        logic signed [10:0] eye_height;
    } cam_t;

    // Divider request and answer.
    typedef struct packed {
        logic        start;
        logic [27:0] num;
        logic [11:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [27:0] quot;
    } div_rsp_t;

endpackage

@@ hdl/tfcc_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit a cycle, unsigned operands.
module tfcc_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  tfcc_pkg::div_req_t  req,
    output tfcc_pkg::div_rsp_t  rsp
);

    logic [27:0] quot_reg;
    logic [27:0] quot_next;
    logic [11:0] rem_reg;
    logic [11:0] rem_next;
    logic [11:0] den_reg;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic [12:0] trial;

    // One shift and subtract step per cycle.
    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quot_reg[27]} - {1'b0, den_reg};
        if (req.start)
        begin
            quot_next = req.num;
            rem_next  = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[12])
            begin
                rem_next = trial[11:0];
            end
            else
            begin
                rem_next = {rem_reg[10:0], quot_reg[27]};
            end
            quot_next = {quot_reg[26:0], ~trial[12]};
            cnt_next  = cnt_reg + 5'd1;
            if (cnt_reg == 5'd27)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

@@ hdl/tfcc_tex_mem.sv @@
`timescale 1ns / 1ps

// Two-surface texture memory, one write and one registered read a cycle.
module tfcc_tex_mem
(
    input  logic        clk,
    input  logic        wr_en,
    input  logic [12:0] wr_addr,
    input  logic [31:0] wr_data,
    input  logic        rd_en,
    input  logic [12:0] rd_addr,
    output logic [31:0] rd_data
);

    logic [31:0] mem [8192];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ hdl/textured_floor_ceiling_caster.sv @@
`timescale 1ns / 1ps

// Floor and ceiling texture caster. A load item is accepted and the next
// item may follow straight away. A pixel item at a nonzero column passes
// through ST_READ, which forms the texel address and reads the texture
// memory, and ST_OUT, which loads the output register. A pixel at column 0
// of a visible row first sets up the row: the bit-serial divider forms the
// row distance, the quotient is taken into a register, one multiplier forms
// the steps and start coordinate one after another, ST_SDIV and ST_FIN store
// the last product, then ST_READ and ST_OUT follow. Horizon and off-screen
// pixels show valid_res 0 in the cycle after acceptance. No new item is
// accepted while a result waits, so a result taken at once lets the next
// item in on the following cycle. The screen width is fixed at 1024 columns.
// Texture contents are undefined until loaded.
module textured_floor_ceiling_caster
#(
    parameter int SCREEN_HEIGHT   = 1024,
    parameter int TEX_WIDTH_LOG2  = 6,
    parameter int TEX_HEIGHT_LOG2 = 6
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tfcc_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tfcc_pkg::out_item_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int HALF   = SCREEN_HEIGHT / 2;
    localparam int WLOG2  = tfcc_pkg::SCREEN_WIDTH_LOG2;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_FIN   = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_OUT   = 7'b0100000,
        ST_SDIV  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    tfcc_pkg::cam_t cam_reg;
    tfcc_pkg::in_item_t item_reg;

    logic signed [47:0] coord_x_reg, coord_y_reg, step_x_reg, step_y_reg;
    logic               row_ok_reg;
    logic        [27:0] dist_reg;
    logic        [1:0]  mul_idx_reg;
    logic signed [47:0] prod_reg;
    logic        [1:0]  prod_idx_reg;
    logic               prod_vld_reg;
    logic               out_valid_reg;
    tfcc_pkg::out_item_t out_reg;

    // ---------------- Configuration port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg.pos_x      <= '0;
            cam_reg.pos_y      <= '0;
            cam_reg.dir_x      <= 18'sd65536;
            cam_reg.dir_y      <= '0;
            cam_reg.plane_x    <= '0;
            cam_reg.plane_y    <= 18'sd43254;
            cam_reg.view_pitch <= '0;
            cam_reg.eye_height <= '0;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[4:2])
                tfcc_pkg::REG_POS_X:      cam_reg.pos_x      <= pwdata[25:0];
                tfcc_pkg::REG_POS_Y:      cam_reg.pos_y      <= pwdata[25:0];
                tfcc_pkg::REG_DIR_X:      cam_reg.dir_x      <= pwdata[17:0];
                tfcc_pkg::REG_DIR_Y:      cam_reg.dir_y      <= pwdata[17:0];
                tfcc_pkg::REG_PLANE_X:    cam_reg.plane_x    <= pwdata[17:0];
                tfcc_pkg::REG_PLANE_Y:    cam_reg.plane_y    <= pwdata[17:0];
                tfcc_pkg::REG_VIEW_PITCH: cam_reg.view_pitch <= pwdata[10:0];
                tfcc_pkg::REG_EYE_HEIGHT: cam_reg.eye_height <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (paddr[4:2])
            tfcc_pkg::REG_POS_X:      prdata = {6'd0, cam_reg.pos_x};
            tfcc_pkg::REG_POS_Y:      prdata = {6'd0, cam_reg.pos_y};
            tfcc_pkg::REG_DIR_X:      prdata = 32'(cam_reg.dir_x);
            tfcc_pkg::REG_DIR_Y:      prdata = 32'(cam_reg.dir_y);
            tfcc_pkg::REG_PLANE_X:    prdata = 32'(cam_reg.plane_x);
            tfcc_pkg::REG_PLANE_Y:    prdata = 32'(cam_reg.plane_y);
            tfcc_pkg::REG_VIEW_PITCH: prdata = 32'(cam_reg.view_pitch);
            tfcc_pkg::REG_EYE_HEIGHT: prdata = 32'(cam_reg.eye_height);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- Input decode ----------------
    logic in_acc;
    logic on_screen;
    logic signed [12:0] row_off;
    logic signed [12:0] numer_px;

    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign on_screen = (32'(in_data.pixel_x) < tfcc_pkg::SCREEN_WIDTH)
                    && (32'(in_data.pixel_y) < SCREEN_HEIGHT);

    // Row offset from the horizon, sign of pitch and eye depends on surface.
    always_comb
    begin
        if (in_data.surface)
        begin
            row_off = 13'(signed'({1'b0, in_data.pixel_y})) - 13'(HALF)
                    + 13'(cam_reg.view_pitch) + 13'(cam_reg.eye_height);
        end
        else
        begin
            row_off = 13'(signed'({1'b0, in_data.pixel_y})) - 13'(HALF)
                    - 13'(cam_reg.view_pitch) - 13'(cam_reg.eye_height);
        end
    end
    assign numer_px = 13'(HALF) + 13'(cam_reg.eye_height);

    // ---------------- Divider ----------------
    tfcc_pkg::div_req_t div_req;
    tfcc_pkg::div_rsp_t div_rsp;
    logic               num_neg_reg;
    logic               start_div;
    logic        [12:0] numer_abs;

    assign numer_abs = numer_px[12] ? -numer_px : numer_px;
    assign start_div = in_acc && in_data.command == tfcc_pkg::CMD_RENDER && on_screen
                    && in_data.pixel_x == 10'd0 && row_off > 13'sd0;
    assign div_req.start = start_div;
    assign div_req.num   = {numer_abs[11:0], 16'd0};
    assign div_req.den   = row_off[11:0];

    tfcc_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ---------------- Multiplier, one product a cycle ----------------
    logic signed [28:0] dist_s;
    logic signed [19:0] mul_b;
    logic signed [48:0] mul_p;

    assign dist_s = num_neg_reg ? -$signed({1'b0, dist_reg}) : $signed({1'b0, dist_reg});
    always_comb
    begin
        case (mul_idx_reg)
            2'd0:    mul_b = 20'(cam_reg.plane_x) <<< 1;
            2'd1:    mul_b = 20'(cam_reg.plane_y) <<< 1;
            2'd2:    mul_b = 20'(cam_reg.dir_x) - 20'(cam_reg.plane_x);
            default: mul_b = 20'(cam_reg.dir_y) - 20'(cam_reg.plane_y);
        endcase
    end
    assign mul_p = 49'(dist_s) * 49'(mul_b);

    // Truncating division toward zero by a power of two.
    function automatic logic signed [47:0] tz_shift(input logic signed [48:0] v,
                                                    input int sh);
        logic signed [48:0] a;
        a = v[48] ? -v : v;
        a = a >>> sh;
        return v[48] ? 48'(-a) : 48'(a);
    endfunction

    logic signed [48:0] prod_wide;
    assign prod_wide = 49'(prod_reg);

    logic signed [47:0] scaled;
    always_comb
    begin
        if (prod_idx_reg[1])
        begin
            scaled = tz_shift(prod_wide, 16);
        end
        else
        begin
            scaled = tz_shift(prod_wide, 16 + WLOG2);
        end
    end

    // ---------------- Texture memory ----------------
    logic [TEX_WIDTH_LOG2-1:0]  tex_x;
    logic [TEX_HEIGHT_LOG2-1:0] tex_y;
    logic [12:0] rd_addr;
    logic [31:0] rd_data;
    logic        rd_en;
    logic        wr_en;

    assign tex_x = coord_x_reg[15 -: TEX_WIDTH_LOG2];
    assign tex_y = coord_y_reg[15 -: TEX_HEIGHT_LOG2];
    assign rd_addr = {item_reg.surface,
                      12'({tex_y, tex_x})};
    assign rd_en = (state_reg == ST_READ);
    assign wr_en = in_acc && in_data.command == tfcc_pkg::CMD_LOAD;

    tfcc_tex_mem u_mem
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr ({in_data.surface, in_data.texel_index}),
        .wr_data (in_data.texel_color),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    logic [19:0] row_idx;
    assign row_idx = item_reg.surface ? 20'(SCREEN_HEIGHT - 1) - 20'(item_reg.pixel_y)
                                      : 20'(item_reg.pixel_y);

    // ---------------- Sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc && in_data.command == tfcc_pkg::CMD_RENDER)
                begin
                    if (!on_screen)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (start_div)
                    begin
                        state_next = ST_DIV;
                    end
                    else if (in_data.pixel_x == 10'd0 || !row_ok_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_DIV:  state_next = div_rsp.done ? ST_MUL : ST_DIV;
            ST_MUL:  state_next = (mul_idx_reg == 2'd3) ? ST_SDIV : ST_MUL;
            ST_SDIV: state_next = ST_FIN;
            ST_FIN:  state_next = ST_READ;
            ST_READ: state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    logic quick_zero;
    assign quick_zero = in_acc && in_data.command == tfcc_pkg::CMD_RENDER
                     && (!on_screen || (!start_div && (in_data.pixel_x == 10'd0
                                                       || !row_ok_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            row_ok_reg    <= 1'b0;
            mul_idx_reg   <= '0;
            prod_vld_reg  <= 1'b0;
            coord_x_reg   <= '0;
            coord_y_reg   <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (quick_zero)
            begin
                out_valid_reg <= 1'b1;
                if (on_screen && in_data.pixel_x == 10'd0)
                begin
                    row_ok_reg <= 1'b0;
                end
            end
            if (start_div)
            begin
                row_ok_reg  <= 1'b1;
                mul_idx_reg <= '0;
            end
            if (state_reg == ST_MUL)
            begin
                mul_idx_reg <= mul_idx_reg + 2'd1;
            end
            prod_vld_reg <= (state_reg == ST_MUL);
            // Store each scaled product as it leaves the multiplier register.
            if (prod_vld_reg)
            begin
                case (prod_idx_reg)
                    2'd0:    step_x_reg  <= scaled;
                    2'd1:    step_y_reg  <= scaled;
                    2'd2:    coord_x_reg <= scaled + 48'(cam_reg.pos_x);
                    default: coord_y_reg <= scaled + 48'(cam_reg.pos_y);
                endcase
            end
            // Advance the coordinate once the texel address has been used.
            if (state_reg == ST_READ)
            begin
                coord_x_reg <= coord_x_reg + step_x_reg;
                coord_y_reg <= coord_y_reg + step_y_reg;
            end
            if (state_reg == ST_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            item_reg <= in_data;
        end
        if (start_div)
        begin
            num_neg_reg <= numer_px[12];
        end
        if (div_rsp.done)
        begin
            dist_reg <= div_rsp.quot;
        end
        prod_reg     <= mul_p[47:0];
        prod_idx_reg <= mul_idx_reg;
        if (quick_zero)
        begin
            out_reg <= '0;
        end
        if (state_reg == ST_OUT)
        begin
            out_reg.valid_res  <= 1'b1;
            out_reg.dest_index <= 20'(row_idx * 20'(tfcc_pkg::SCREEN_WIDTH))
                                + 20'(item_reg.pixel_x);
            out_reg.color      <= rd_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- Checks ----------------
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input accepted while busy");
    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside set-up");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("result dropped while stalled");
    a_row_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> row_ok_reg)
        else $error("row set-up inconsistent");

endmodule

@@ dv/textured_floor_ceiling_caster_test.sv @@
`timescale 1ns / 1ps

module textured_floor_ceiling_caster_test;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    tfcc_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    tfcc_pkg::out_item_t out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    textured_floor_ceiling_caster u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted camera registers and caster state.
    tfcc_pkg::cam_t cam;
    logic [47:0] tex_u, tex_v, step_u, step_v;
    logic        row_live;
    logic [31:0] texels [0:8191];
    bit          texel_loaded [0:8191];

    tfcc_pkg::in_item_t  pending_items [$];
    tfcc_pkg::out_item_t expected_pixels [$];
    int          error_count = 0;
    int          pixels_seen = 0;
    int          items_queued = 0;

    task automatic report_mismatch(input string what);
        $display("tb: mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    // Row set-up: row distance, per-pixel step and start coordinate.
    task automatic set_up_row(input logic surf, input logic [9:0] y);
        longint half, p, row_dist, dx, dy, px, py, pitch, eye;
        half  = 512;
        dx    = longint'(cam.dir_x);
        dy    = longint'(cam.dir_y);
        px    = longint'(cam.plane_x);
        py    = longint'(cam.plane_y);
        pitch = longint'(cam.view_pitch);
        eye   = longint'(cam.eye_height);
        p = surf ? (longint'(y) - half + pitch + eye) : (longint'(y) - half - pitch - eye);
        if (p <= 0)
        begin
            row_live = 1'b0;
            return;
        end
        row_live = 1'b1;
        row_dist = ((half + eye) * 65536) / p;
        step_u = 48'(row_dist * 2 * px / (longint'(1024) * 65536));
        step_v = 48'(row_dist * 2 * py / (longint'(1024) * 65536));
        tex_u  = 48'(longint'(cam.pos_x) + row_dist * (dx - px) / 65536);
        tex_v  = 48'(longint'(cam.pos_y) + row_dist * (dy - py) / 65536);
    endtask

    // Works out one rendered pixel; fetch tells whether the texture is read.
    task automatic cast_pixel(input logic surf, input logic [9:0] x, input logic [9:0] y,
                              output tfcc_pkg::out_item_t px_out, output logic [12:0] addr,
                              output logic fetch);
        logic [9:0] row;
        px_out = '0;
        fetch  = 1'b0;
        addr   = '0;
        if (x == 10'd0)
            set_up_row(surf, y);
        if (!row_live)
            return;
        addr   = {surf, tex_v[15:10], tex_u[15:10]};
        fetch  = 1'b1;
        tex_u  = tex_u + step_u;
        tex_v  = tex_v + step_v;
        row    = surf ? 10'(1023 - y) : y;
        px_out.valid_res  = 1'b1;
        px_out.dest_index = {row, x};
        px_out.color      = texels[addr];
    endtask

    task automatic queue_load(input logic surf, input logic [11:0] idx, input logic [31:0] c);
        tfcc_pkg::in_item_t it;
        it = '0;
        it.command     = tfcc_pkg::CMD_LOAD;
        it.surface     = surf;
        it.texel_index = idx;
        it.texel_color = c;
        it.pixel_x     = 10'($urandom);
        it.pixel_y     = 10'($urandom);
        texels[{surf, idx}]       = c;
        texel_loaded[{surf, idx}] = 1'b1;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // A pixel that would read an unloaded texel gets that texel loaded first.
    task automatic queue_pixel(input logic surf, input logic [9:0] x, input logic [9:0] y);
        tfcc_pkg::in_item_t  it;
        tfcc_pkg::out_item_t px_out;
        logic [12:0] addr;
        logic        fetch;
        logic [47:0] su, sv, ssu, ssv;
        logic        slive;
        su = tex_u; sv = tex_v; ssu = step_u; ssv = step_v; slive = row_live;
        cast_pixel(surf, x, y, px_out, addr, fetch);
        if (fetch && !texel_loaded[addr])
        begin
            tex_u = su; tex_v = sv; step_u = ssu; step_v = ssv; row_live = slive;
            queue_load(addr[12], addr[11:0], $urandom);
            cast_pixel(surf, x, y, px_out, addr, fetch);
        end
        it = '0;
        it.command     = tfcc_pkg::CMD_RENDER;
        it.surface     = surf;
        it.texel_index = 12'($urandom);
        it.texel_color = $urandom;
        it.pixel_x     = x;
        it.pixel_y     = y;
        pending_items.push_back(it);
        expected_pixels.push_back(px_out);
        items_queued++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            tfcc_pkg::REG_POS_X:      cam.pos_x      = value[25:0];
            tfcc_pkg::REG_POS_Y:      cam.pos_y      = value[25:0];
            tfcc_pkg::REG_DIR_X:      cam.dir_x      = value[17:0];
            tfcc_pkg::REG_DIR_Y:      cam.dir_y      = value[17:0];
            tfcc_pkg::REG_PLANE_X:    cam.plane_x    = value[17:0];
            tfcc_pkg::REG_PLANE_Y:    cam.plane_y    = value[17:0];
            tfcc_pkg::REG_VIEW_PITCH: cam.view_pitch = value[10:0];
            default:                  cam.eye_height = value[10:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0)
            @(posedge clk);
        // A trailing load or row set-up may still be in flight.
        repeat (60) @(posedge clk);
    endtask

    task automatic random_camera();
        write_reg(tfcc_pkg::REG_POS_X, $urandom);
        write_reg(tfcc_pkg::REG_POS_Y, $urandom);
        write_reg(tfcc_pkg::REG_DIR_X, $urandom);
        write_reg(tfcc_pkg::REG_DIR_Y, $urandom);
        write_reg(tfcc_pkg::REG_PLANE_X, $urandom);
        write_reg(tfcc_pkg::REG_PLANE_Y, $urandom);
        write_reg(tfcc_pkg::REG_VIEW_PITCH,
                  $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 40)));
        write_reg(tfcc_pkg::REG_EYE_HEIGHT,
                  $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 40)));
    endtask

    // Mostly runs from column 0 of a row in raster order, with stray pixels and loads between.
    // The count covers every queued item, texel loads included.
    task automatic random_traffic(input int count);
        int          start, len, k;
        logic        surf;
        logic [9:0]  y, x0;
        start = items_queued;
        while (items_queued - start < count)
        begin
            k = $urandom_range(0, 9);
            surf = 1'($urandom);
            if (k < 7)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
                y = ($urandom_range(0, 2) == 0) ? 10'($urandom_range(490, 540)) : 10'($urandom);
                x0 = 10'd0;
                for (int i = 0; i < len; i++)
                    queue_pixel(surf, x0 + 10'(i), y);
            end
            else if (k < 9)
            begin
                queue_load(surf, 12'($urandom), $urandom);
            end
            else
            begin
                queue_pixel(surf, 10'($urandom_range(1, 1023)), 10'($urandom));
            end
        end
    endtask

    // Stimulus and phase control.
    initial
    begin
        cam = '0;
        cam.dir_x   = 18'sd65536;
        cam.plane_y = 18'sd43254;
        tex_u = '0; tex_v = '0; step_u = '0; step_v = '0;
        row_live = 1'b0;
        for (int i = 0; i < 8192; i++)
        begin
            texels[i] = '0;
            texel_loaded[i] = 1'b0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset camera first, then field extremes.
        queue_load(1'b0, 12'd0, 32'h0000_0000);
        queue_load(1'b1, 12'd4095, 32'hFFFF_FFFF);
        queue_pixel(1'b0, 10'd5, 10'd700);
        queue_pixel(1'b0, 10'd0, 10'd1023);
        queue_pixel(1'b0, 10'd1, 10'd1023);
        queue_pixel(1'b0, 10'd2, 10'd1023);
        queue_pixel(1'b1, 10'd0, 10'd1023);
        queue_pixel(1'b1, 10'd1, 10'd1023);
        queue_pixel(1'b0, 10'd0, 10'd512);
        queue_pixel(1'b0, 10'd1, 10'd512);
        queue_pixel(1'b1, 10'd0, 10'd0);
        queue_pixel(1'b0, 10'd0, 10'd513);
        queue_pixel(1'b1, 10'd1023, 10'd513);
        queue_pixel(1'b0, 10'd0, 10'd1000);
        queue_pixel(1'b0, 10'd1023, 10'd1000);
        wait_drained();

        write_reg(tfcc_pkg::REG_POS_X, 32'h03FF_FFFF);
        write_reg(tfcc_pkg::REG_POS_Y, 32'h03FF_FFFF);
        write_reg(tfcc_pkg::REG_DIR_X, 32'h0002_0000);
        write_reg(tfcc_pkg::REG_DIR_Y, 32'h0001_FFFF);
        write_reg(tfcc_pkg::REG_PLANE_X, 32'h0001_FFFF);
        write_reg(tfcc_pkg::REG_PLANE_Y, 32'h0002_0000);
        write_reg(tfcc_pkg::REG_VIEW_PITCH, 32'h0000_03FF);
        write_reg(tfcc_pkg::REG_EYE_HEIGHT, 32'h0000_0400);
        queue_pixel(1'b1, 10'd0, 10'd1023);
        queue_pixel(1'b1, 10'd1, 10'd1023);
        queue_pixel(1'b0, 10'd0, 10'd1023);
        queue_pixel(1'b0, 10'd0, 10'd0);
        random_traffic(250);
        wait_drained();

        write_reg(tfcc_pkg::REG_POS_X, 32'h0);
        write_reg(tfcc_pkg::REG_POS_Y, 32'h0);
        write_reg(tfcc_pkg::REG_VIEW_PITCH, 32'h0000_0400);
        write_reg(tfcc_pkg::REG_EYE_HEIGHT, 32'h0000_03FF);
        random_traffic(250);
        wait_drained();

        for (int ph = 0; ph < 5; ph++)
        begin
            random_camera();
            random_traffic(270);
            wait_drained();
        end

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Driver: one item at a time, with a random gap before each.
    logic in_fired = 1'b0;
    int   in_gap = 0;

    always @(posedge clk)
        in_fired <= in_valid && in_ready;

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fired))
        begin
            if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                in_data  <= pending_items.pop_front();
                in_valid <= 1'b1;
                in_gap   <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here, once some pixels have gone by.
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(negedge clk)
    begin
        if (!hold_done && pixels_seen == 300)
        begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: random stalls, and each accepted item checked against the oldest prediction.
    int out_gap = 0;

    always @(negedge clk)
    begin
        if (hold_left > 0 || (!hold_done && pixels_seen == 300))
            out_ready <= 1'b0;
        else if (out_gap > 0)
        begin
            out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_valid && out_ready)
                out_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
        end
    end

    always @(posedge clk)
    begin
        tfcc_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            pixels_seen <= pixels_seen + 1;
            if (expected_pixels.size() == 0)
                report_mismatch("pixel item with none expected");
            else
            begin
                want = expected_pixels.pop_front();
                if (out_data.valid_res !== want.valid_res)
                    report_mismatch($sformatf("valid_res %0b, want %0b",
                                              out_data.valid_res, want.valid_res));
                if (out_data.dest_index !== want.dest_index)
                    report_mismatch($sformatf("dest_index %0d, want %0d",
                                              out_data.dest_index, want.dest_index));
                if (out_data.color !== want.color)
                    report_mismatch($sformatf("color %08h, want %08h",
                                              out_data.color, want.color));
            end
        end
    end

    // Watchdog.
    initial
    begin
        #40ms;
        $display("tb: failure");
        $finish;
    end

endmodule
